>>> design/clsp_pkg.sv
// Shared constants and types of the combined shuffled congruential generator.
package clsp_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int WARMUP      = 8;
    localparam int VAL_W       = 31;
    localparam int MUL_W       = 16;
    localparam int FOLD_W      = 8;
    localparam int PROD_W      = VAL_W + MUL_W;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SEED_STEPS  = TABLE_DEPTH + WARMUP;
    localparam int CNT_W       = $clog2(SEED_STEPS);

    // 2**31 is congruent to FOLD_x modulo MOD_x
    localparam logic [VAL_W-1:0]  MOD_A    = 31'd2147483563;
    localparam logic [VAL_W-1:0]  MOD_B    = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_A    = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_B    = 16'd40692;
    localparam logic [FOLD_W-1:0] FOLD_A   = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_B   = 8'd249;
    localparam logic [VAL_W-1:0]  TOP_OUT  = 31'd2147483562;
    localparam logic [VAL_W-1:0]  RESET_A  = 31'd1;
    localparam logic [VAL_W-1:0]  RESET_B  = 31'd123456789;
    localparam logic [31:0]       SLOT_DIV = 32'(1 + 2147483562 / TABLE_DEPTH);

    typedef enum logic {
        GEN_A = 1'b0,
        GEN_B = 1'b1
    } t_gen_sel;

    typedef enum logic {
        KIND_DRAW = 1'b0,
        KIND_SEED = 1'b1
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEED  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_DRAW  = 5'b01000,
        S_FIX   = 5'b10000
    } t_state;

endpackage

>>> design/clsp_mulmod.sv
// Three-stage constant modular multiply: result = (MUL * value) mod MOD.
module clsp_mulmod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  clsp_pkg::t_gen_sel             i_sel,
    input  logic [clsp_pkg::VAL_W-1:0]     i_value,
    output logic                           o_done,
    output logic [clsp_pkg::VAL_W-1:0]     o_result
);

    logic [clsp_pkg::MUL_W-1:0]              w_mul;
    logic [clsp_pkg::FOLD_W-1:0]             w_fold;
    logic [clsp_pkg::VAL_W-1:0]              w_mod;
    logic [clsp_pkg::MUL_W-1:0]              w_hi;
    logic [clsp_pkg::MUL_W+clsp_pkg::FOLD_W-1:0] w_hi_fold;

    logic [clsp_pkg::PROD_W-1:0]  r_prod;
    logic [clsp_pkg::VAL_W:0]     r_sum;
    logic [clsp_pkg::VAL_W-1:0]   r_res;
    clsp_pkg::t_gen_sel           r_sel1;
    clsp_pkg::t_gen_sel           r_sel2;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;

    always_comb begin
        w_mul  = (i_sel == clsp_pkg::GEN_B) ? clsp_pkg::MUL_B : clsp_pkg::MUL_A;
        w_fold = (r_sel1 == clsp_pkg::GEN_B) ? clsp_pkg::FOLD_B : clsp_pkg::FOLD_A;
        w_mod  = (r_sel2 == clsp_pkg::GEN_B) ? clsp_pkg::MOD_B : clsp_pkg::MOD_A;
        w_hi   = r_prod[clsp_pkg::PROD_W-1:clsp_pkg::VAL_W];
        w_hi_fold = (clsp_pkg::MUL_W+clsp_pkg::FOLD_W)'(w_hi)
                  * (clsp_pkg::MUL_W+clsp_pkg::FOLD_W)'(w_fold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // full product
        r_prod <= clsp_pkg::PROD_W'(w_mul) * clsp_pkg::PROD_W'(i_value);
        r_sel1 <= i_sel;
        // fold the bits above 2**31 back in; the sum stays below twice the modulus
        r_sum  <= (clsp_pkg::VAL_W+1)'(r_prod[clsp_pkg::VAL_W-1:0])
                + (clsp_pkg::VAL_W+1)'(w_hi_fold);
        r_sel2 <= r_sel1;
        // one conditional subtract finishes the reduction
        if (r_sum >= {1'b0, w_mod}) begin
            r_res <= clsp_pkg::VAL_W'(r_sum - {1'b0, w_mod});
        end else begin
            r_res <= r_sum[clsp_pkg::VAL_W-1:0];
        end
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule

>>> design/combined_lcg_shuffle_prng_core.sv
// Top level of the combined shuffled congruential random number generator.
//
// Each request on the slave stream yields one 31-bit integer in 1..2147483562 on the
// master stream. tuser[0] selects the request kind: 0 draws the next number, 1 reseeds
// from tdata[30:0] (zero is taken as one) and then draws. Two multiplicative generators
// (multipliers 40014 and 40692, moduli 2147483563 and 2147483399) each run through a
// three-stage modular multiply; the previous output indexes a 32-entry shuffle table that
// the first generator's result refreshes, held in a synchronous RAM with a registered read
// port. On acceptance a draw issues the table read and both multiplies, waits for the
// multiply results, and then wraps the difference into range before the next request
// can be accepted; the wrap waits until the output register is free. A reseed runs
// 8 warm-up steps plus one step per table entry through the first generator's multiply.
// The result sits in an output register, so a new request is accepted while the previous
// result still waits for the consumer. Scaling to a fraction is left to the consumer.
// Table entries read before their first write return zero.
module combined_lcg_shuffle_prng_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] seed_value, [31] zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [30:0] draw_value, [31] zero
);

    localparam int VW = clsp_pkg::VAL_W;

    // Slot = last_output / SLOT_DIV; the thresholds are elaboration constants.
    function automatic logic [clsp_pkg::SLOT_W-1:0] slot_of(input logic [VW-1:0] y);
        logic [clsp_pkg::SLOT_W-1:0] s;
        logic [31:0]                 thr;
        s   = '0;
        thr = '0;
        for (int t = 1; t < clsp_pkg::TABLE_DEPTH; t++) begin
            thr = 32'(t) * clsp_pkg::SLOT_DIV;
            if ({1'b0, y} >= thr) begin
                s = clsp_pkg::SLOT_W'(t);
            end
        end
        return s;
    endfunction

    clsp_pkg::t_state r_state;
    clsp_pkg::t_state n_state;

    logic [VW-1:0]                 r_gen_a;
    logic [VW-1:0]                 r_gen_b;
    logic [VW-1:0]                 r_last;
    logic [clsp_pkg::CNT_W-1:0]    r_cnt;
    logic [clsp_pkg::SLOT_W-1:0]   r_slot_q;
    logic [VW:0]                   r_diff;
    logic                          r_out_valid;
    logic [VW-1:0]                 r_out_data;

    // shuffle table RAM and per-entry written flags
    logic [VW-1:0]                 r_table [clsp_pkg::TABLE_DEPTH];
    logic [clsp_pkg::TABLE_DEPTH-1:0] r_tvld;
    logic [VW-1:0]                 r_rd_q;
    logic                          r_rd_vld;

    logic                          w_in_acc;
    logic                          w_is_seed;
    logic [VW-1:0]                 w_seed;
    logic                          w_issue;
    logic [clsp_pkg::SLOT_W-1:0]   w_slot;
    logic                          w_a_start;
    logic [VW-1:0]                 w_a_value;
    logic                          w_a_done;
    logic [VW-1:0]                 w_a_res;
    logic                          w_b_done;
    logic [VW-1:0]                 w_b_res;
    logic                          w_both_done;
    logic                          w_seed_last;
    logic                          w_wr_en;
    logic [clsp_pkg::SLOT_W-1:0]   w_wr_addr;
    logic [VW-1:0]                 w_rd;
    logic [VW-1:0]                 w_y;
    logic                          w_out_free;
    logic                          w_finish;

    always_comb begin
        w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
        w_is_seed   = (clsp_pkg::t_kind'(i_s_axis_tuser[0]) == clsp_pkg::KIND_SEED);
        w_seed      = (i_s_axis_tdata[VW-1:0] == '0) ? VW'(1) : i_s_axis_tdata[VW-1:0];
        w_slot      = slot_of(r_last);
        w_both_done = w_a_done && w_b_done;
        w_seed_last = (r_cnt == '0);
        w_out_free  = !r_out_valid || i_m_axis_tready;
        w_finish    = (r_state == clsp_pkg::S_FIX) && w_out_free;

        // issue a draw: read the slot and start both generators
        w_issue = ((r_state == clsp_pkg::S_IDLE) && w_in_acc && !w_is_seed)
               || (r_state == clsp_pkg::S_ISSUE);

        w_a_start = w_issue
                 || ((r_state == clsp_pkg::S_IDLE) && w_in_acc && w_is_seed)
                 || ((r_state == clsp_pkg::S_SEED) && w_a_done && !w_seed_last);
        if (r_state == clsp_pkg::S_IDLE && w_is_seed) begin
            w_a_value = w_seed;
        end else if (r_state == clsp_pkg::S_SEED) begin
            w_a_value = w_a_res;
        end else begin
            w_a_value = r_gen_a;
        end

        // table writes: fill during reseed, replace the used slot on a draw
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot_q;
        if (r_state == clsp_pkg::S_SEED) begin
            w_wr_en   = w_a_done && (r_cnt < clsp_pkg::CNT_W'(clsp_pkg::TABLE_DEPTH));
            w_wr_addr = r_cnt[clsp_pkg::SLOT_W-1:0];
        end else if (r_state == clsp_pkg::S_DRAW) begin
            w_wr_en   = w_both_done;
        end

        w_rd = r_rd_vld ? r_rd_q : '0;

        // wrap the difference into 1..TOP_OUT
        if (r_diff[VW] || r_diff == '0) begin
            w_y = VW'(r_diff + {1'b0, clsp_pkg::TOP_OUT});
        end else begin
            w_y = r_diff[VW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            clsp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_is_seed ? clsp_pkg::S_SEED : clsp_pkg::S_DRAW;
                end
            end
            clsp_pkg::S_SEED: begin
                if (w_a_done && w_seed_last) begin
                    n_state = clsp_pkg::S_ISSUE;
                end
            end
            clsp_pkg::S_ISSUE: begin
                n_state = clsp_pkg::S_DRAW;
            end
            clsp_pkg::S_DRAW: begin
                if (w_both_done) begin
                    n_state = clsp_pkg::S_FIX;
                end
            end
            clsp_pkg::S_FIX: begin
                if (w_out_free) begin
                    n_state = clsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clsp_pkg::S_IDLE;
            end
        endcase
    end

    clsp_mulmod u_gen_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_a_start),
        .i_sel    (clsp_pkg::GEN_A),
        .i_value  (w_a_value),
        .o_done   (w_a_done),
        .o_result (w_a_res)
    );

    clsp_mulmod u_gen_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_issue),
        .i_sel    (clsp_pkg::GEN_B),
        .i_value  (r_gen_b),
        .o_done   (w_b_done),
        .o_result (w_b_res)
    );

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clsp_pkg::S_IDLE;
            r_gen_a     <= clsp_pkg::RESET_A;
            r_gen_b     <= clsp_pkg::RESET_B;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_tvld      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == clsp_pkg::S_IDLE && w_in_acc && w_is_seed) begin
                r_gen_a <= w_seed;
                r_gen_b <= w_seed;
            end
            if (r_state == clsp_pkg::S_SEED && w_a_done) begin
                r_gen_a <= w_a_res;
                if (w_seed_last) begin
                    r_last <= w_a_res;
                end
            end
            if (r_state == clsp_pkg::S_DRAW && w_both_done) begin
                r_gen_a <= w_a_res;
                r_gen_b <= w_b_res;
            end
            if (w_wr_en) begin
                r_tvld[w_wr_addr] <= 1'b1;
            end
            // hold the result until taken; load a new one when the slot frees
            if (w_finish) begin
                r_last      <= w_y;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == clsp_pkg::S_IDLE && w_in_acc && w_is_seed) begin
            r_cnt <= clsp_pkg::CNT_W'(clsp_pkg::SEED_STEPS - 1);
        end else if (r_state == clsp_pkg::S_SEED && w_a_done && !w_seed_last) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (w_issue) begin
            r_slot_q <= w_slot;
        end
        if (r_state == clsp_pkg::S_DRAW && w_both_done) begin
            r_diff <= {1'b0, w_rd} - {1'b0, w_b_res};
        end
        if (w_finish) begin
            r_out_data <= w_y;
        end
    end

    // shuffle table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= w_a_res;
        end
        if (w_issue) begin
            r_rd_q   <= r_table[w_slot];
            r_rd_vld <= r_tvld[w_slot];
        end
    end

    assign o_s_axis_tready = (r_state == clsp_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

endmodule

>>> tb/combined_lcg_shuffle_prng_core_tb.sv
// Self-checking testbench for the combined shuffled congruential random number generator.
module combined_lcg_shuffle_prng_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Schrage factors of the two multiplicative generators (m = a * q + r).
    localparam longint QUO_A = 53668;
    localparam longint REM_A = 12211;
    localparam longint QUO_B = 52774;
    localparam longint REM_B = 3791;

    // Latency of a reseed request, plus margin, used for the drain at the end.
    localparam int DRAIN_CYCLES = 3 * clsp_pkg::SEED_STEPS + 20;
    localparam int RAND_PER_PHASE = 433;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [30:0] seed_value, [31] zero
    logic [0:0]  i_s_axis_tuser = '0;   // [0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [30:0] draw_value, [31] zero

    combined_lcg_shuffle_prng_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run (all reseeds under heavy stalls).
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: both generators, the previous draw and the table.
    // ------------------------------------------------------------------
    longint gen_a_val;
    longint gen_b_val;
    longint prev_draw;
    longint shuffle_mem [clsp_pkg::TABLE_DEPTH];

    logic [30:0] pending_draws [$];
    int          mismatch_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // One Schrage step: (a * z) mod m without overflow.
    function automatic longint mcg_step(longint z, longint a, longint q, longint r,
                                        longint m);
        longint k;
        longint v;
        k = z / q;
        v = a * (z - k * q) - k * r;
        if (v < 0) v += m;
        return v;
    endfunction

    // Advance the predictor by one request and return the draw it must produce.
    function automatic logic [30:0] predict_draw(clsp_pkg::t_kind kind, logic [30:0] seed);
        longint s;
        longint slot;
        longint y;
        if (kind == clsp_pkg::KIND_SEED) begin
            s = longint'(seed);
            if (s < 1) s = 1;   // zero seed is taken as one
            gen_a_val = s;
            gen_b_val = s;
            // warm-up steps first, then fill the table from the top entry down
            for (int j = clsp_pkg::SEED_STEPS - 1; j >= 0; j--) begin
                gen_a_val = mcg_step(gen_a_val, clsp_pkg::MUL_A, QUO_A, REM_A,
                                     clsp_pkg::MOD_A);
                if (j < clsp_pkg::TABLE_DEPTH) shuffle_mem[j] = gen_a_val;
            end
            prev_draw = shuffle_mem[0];
        end
        gen_a_val = mcg_step(gen_a_val, clsp_pkg::MUL_A, QUO_A, REM_A, clsp_pkg::MOD_A);
        gen_b_val = mcg_step(gen_b_val, clsp_pkg::MUL_B, QUO_B, REM_B, clsp_pkg::MOD_B);
        slot = prev_draw / longint'(clsp_pkg::SLOT_DIV);
        if (slot < 0) slot = 0;
        if (slot >= clsp_pkg::TABLE_DEPTH) slot = clsp_pkg::TABLE_DEPTH - 1;
        y = shuffle_mem[slot] - gen_b_val;
        shuffle_mem[slot] = gen_a_val;
        if (y < 1) y += longint'(clsp_pkg::TOP_OUT);
        prev_draw = y;
        return y[30:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Directed requests. A nonzero typed flag means the draw is known by
    // hand; all other rows are checked against the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        clsp_pkg::t_kind kind;
        logic [30:0]     seed;
        logic            typed;
        logic [30:0]     want;
    } t_req_row;

    localparam int N_DIRECTED = 23;

    t_req_row directed_rows [N_DIRECTED] = '{
        // first draw after reset: zero table, slot 0, result wraps to TOP_OUT - w
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b1, 31'd1407495835},
        '{clsp_pkg::KIND_DRAW, 31'h7FFF_FFFF,  1'b0, 31'd0},   // seed bits ignored on a draw
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd0,          1'b0, 31'd0},   // zero seed acts as one
        '{clsp_pkg::KIND_DRAW, 31'h2AAA_AAAA,  1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd1,          1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'h5555_5555,  1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'h7FFF_FFFF,  1'b0, 31'd0},   // largest seed, above both moduli
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd2147483563, 1'b0, 31'd0},   // first generator collapses to zero
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd2147483562, 1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd2147483399, 1'b0, 31'd0},   // second generator collapses to zero
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'h5555_5555,  1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'h2AAA_AAAA,  1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd2147483564, 1'b0, 31'd0},
        '{clsp_pkg::KIND_SEED, 31'd123456789,  1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'd1,          1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'd0,          1'b0, 31'd0},
        '{clsp_pkg::KIND_DRAW, 31'h7FFF_FFFF,  1'b0, 31'd0}
    };

    // Offer one request; hold it until accepted, then queue its expected draw.
    task automatic send_request(input clsp_pkg::t_kind kind, input logic [30:0] seed,
                                input logic typed, input logic [30:0] want);
        logic [30:0] draw;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, seed};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        draw = predict_draw(kind, seed);
        pending_draws.push_back(typed ? want : draw);
    endtask

    // Seeds lean on the edges: zero, one, the moduli and all ones.
    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 15))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return clsp_pkg::MOD_A;
            3:       return clsp_pkg::TOP_OUT;
            4:       return 31'h7FFF_FFFF;
            5:       return clsp_pkg::MOD_B;
            6:       return 31'($urandom_range(2, 100));
            default: return 31'($urandom);
        endcase
    endfunction

    // Receiver: drop tready for the current share of cycles.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every accepted result against the oldest pending draw.
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_draws.size() == 0) begin
                flag_mismatch($sformatf("result %0d with no request pending",
                                        o_m_axis_tdata[30:0]));
            end else begin
                want = pending_draws.pop_front();
                if (o_m_axis_tdata[30:0] !== want)
                    flag_mismatch($sformatf("draw_value got %0d, want %0d",
                                            o_m_axis_tdata[30:0], want));
                if (o_m_axis_tdata[31] !== 1'b0)
                    flag_mismatch("padding bit of tdata is not zero");
            end
        end
    end

    initial begin
        clsp_pkg::t_kind kind;
        gen_a_val = longint'(clsp_pkg::RESET_A);
        gen_b_val = longint'(clsp_pkg::RESET_B);
        prev_draw = 0;
        foreach (shuffle_mem[i]) shuffle_mem[i] = 0;

        // hold reset, then release it on a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 67;
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].seed,
                         directed_rows[i].typed, directed_rows[i].want);

        // three idling profiles: slow receiver, slow sender, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 23 : 0;
            repeat (RAND_PER_PHASE) begin
                kind = ($urandom_range(0, 11) == 0) ? clsp_pkg::KIND_SEED
                                                    : clsp_pkg::KIND_DRAW;
                send_request(kind, pick_seed(), 1'b0, 31'd0);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_draws.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
